/* design/pfa_pkg.sv */
// Package for the primitive face assembler: index width, topology codes,
// register indexes, face record and output queue sizing. No dependencies.
package pfa_pkg;

  localparam int INDEX_BITS = 32;
  localparam logic [31:0] IDX_MASK = 32'((64'd1 << INDEX_BITS) - 64'd1);

  typedef enum logic [2:0] {
    MODE_POINTS    = 3'd0,
    MODE_LINES     = 3'd1,
    MODE_TRIANGLES = 3'd2,
    MODE_LINE_STRIP = 3'd3,
    MODE_LINE_LOOP = 3'd4,
    MODE_TRI_STRIP = 3'd5,
    MODE_TRI_FAN   = 3'd6
  } prim_mode_e;

  localparam logic REG_PRIM_MODE  = 1'b0;
  localparam logic REG_AUTO_INDEX = 1'b1;

  localparam logic [2:0] PRIM_MODE_RESET = 3'd2;

  localparam logic [1:0] CNT_POINT = 2'd1;
  localparam logic [1:0] CNT_LINE  = 2'd2;
  localparam logic [1:0] CNT_TRI   = 2'd3;

  typedef struct packed {
    logic        final_of_item;
    logic [1:0]  corner_count;
    logic [31:0] corner_c;
    logic [31:0] corner_b;
    logic [31:0] corner_a;
  } face_t;

  // up to two faces produced by one vertex beat
  typedef struct packed {
    logic  v0;
    logic  v1;
    face_t f0;
    face_t f1;
  } face_pair_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

/* design/pfa_core.sv */
// Assembly state and face generation for one vertex beat per cycle while accept_i is high.
// Holds the configuration registers. Depends on pfa_pkg.
module pfa_core
  import pfa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        accept_i,
  input  logic [31:0] vertex_index_i,
  input  logic        last_i,
  output face_pair_t  faces_o
);

  logic [2:0]  prim_mode_q;
  logic        auto_index_q;
  logic [31:0] first_q, first_d;
  logic [31:0] prev_q, prev_d;
  logic [31:0] older_q, older_d;
  logic [31:0] pos_q, pos_d;
  logic [1:0]  fill_q, fill_d;

  logic [31:0] idx;
  logic [1:0]  sat;
  face_pair_t  fp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prim_mode_q  <= PRIM_MODE_RESET;
      auto_index_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PRIM_MODE:  prim_mode_q  <= cfg_wdata_i;
        REG_AUTO_INDEX: auto_index_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    idx = (auto_index_q ? pos_q : vertex_index_i) & IDX_MASK;
    sat = (fill_q >= 2'd2) ? 2'd2 : fill_q + 2'd1;
    fp       = '0;
    fill_d   = fill_q;
    first_d  = first_q;

    case (prim_mode_e'(prim_mode_q))
      MODE_POINTS: begin
        fp.v0 = 1'b1;
        fp.f0.corner_a = idx;
        fp.f0.corner_count = CNT_POINT;
      end
      MODE_LINES: begin
        if (fill_q == 2'd0) begin
          fill_d = 2'd1;
        end else begin
          fp.v0 = 1'b1;
          fp.f0.corner_a = prev_q;
          fp.f0.corner_b = idx;
          fp.f0.corner_count = CNT_LINE;
          fill_d = 2'd0;
        end
      end
      MODE_TRIANGLES: begin
        if (fill_q >= 2'd2) begin
          fp.v0 = 1'b1;
          fp.f0.corner_a = older_q;
          fp.f0.corner_b = prev_q;
          fp.f0.corner_c = idx;
          fp.f0.corner_count = CNT_TRI;
          fill_d = 2'd0;
        end else begin
          fill_d = fill_q + 2'd1;
        end
      end
      MODE_LINE_STRIP: begin
        if (fill_q >= 2'd1) begin
          fp.v0 = 1'b1;
          fp.f0.corner_a = prev_q;
          fp.f0.corner_b = idx;
          fp.f0.corner_count = CNT_LINE;
        end
        fill_d = sat;
      end
      MODE_LINE_LOOP: begin
        if (fill_q == 2'd0) begin
          first_d = idx;
        end else begin
          fp.v0 = 1'b1;
          fp.f0.corner_a = prev_q;
          fp.f0.corner_b = idx;
          fp.f0.corner_count = CNT_LINE;
          // closing edge back to the first vertex
          if (last_i) begin
            fp.v1 = 1'b1;
            fp.f1.corner_a = idx;
            fp.f1.corner_b = first_q;
            fp.f1.corner_count = CNT_LINE;
          end
        end
        fill_d = sat;
      end
      MODE_TRI_STRIP: begin
        if (fill_q >= 2'd2) begin
          fp.v0 = 1'b1;
          fp.f0.corner_a = pos_q[0] ? prev_q : older_q;
          fp.f0.corner_b = pos_q[0] ? older_q : prev_q;
          fp.f0.corner_c = idx;
          fp.f0.corner_count = CNT_TRI;
        end
        fill_d = sat;
      end
      MODE_TRI_FAN: begin
        if (fill_q == 2'd0) begin
          first_d = idx;
        end
        if (fill_q >= 2'd2) begin
          fp.v0 = 1'b1;
          fp.f0.corner_a = first_q;
          fp.f0.corner_b = prev_q;
          fp.f0.corner_c = idx;
          fp.f0.corner_count = CNT_TRI;
        end
        fill_d = sat;
      end
      default: ;
    endcase

    fp.f0.final_of_item = !fp.v1;
    fp.f1.final_of_item = 1'b1;

    older_d = prev_q;
    prev_d  = idx;
    pos_d   = pos_q + 32'd1;

    if (last_i) begin
      first_d = '0;
      prev_d  = '0;
      older_d = '0;
      pos_d   = '0;
      fill_d  = '0;
    end

    faces_o    = fp;
    faces_o.v0 = fp.v0 & accept_i;
    faces_o.v1 = fp.v1 & accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      prev_q  <= '0;
      older_q <= '0;
      pos_q   <= '0;
      fill_q  <= '0;
    end else if (accept_i) begin
      first_q <= first_d;
      prev_q  <= prev_d;
      older_q <= older_d;
      pos_q   <= pos_d;
      fill_q  <= fill_d;
    end
  end

endmodule

/* design/pfa_face_fifo.sv */
// Small output queue of faces: up to two pushes and one pop per cycle.
// Depends on pfa_pkg.
module pfa_face_fifo
  import pfa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  face_pair_t push_i,
  output logic       room2_o,
  output logic       valid_o,
  input  logic       pop_i,
  output face_t      face_o
);

  face_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic [QPTR_W-1:0]  wptr_p1;
  logic               pop;
  logic [1:0]         npush;

  assign wptr_p1 = wptr_q + QPTR_W'(1);
  assign pop     = pop_i & valid_o;
  assign npush   = {1'b0, push_i.v0} + {1'b0, push_i.v1};
  assign valid_o = (cnt_q != '0);
  assign room2_o = (cnt_q <= QCNT_W'(QDEPTH - 2));
  assign face_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q + QPTR_W'(npush);
    rptr_d = rptr_q + QPTR_W'(pop);
    cnt_d  = cnt_q + QCNT_W'(npush) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  for (genvar i = 0; i < QDEPTH; i++) begin : g_ent
    always_ff @(posedge clk_i) begin
      if (push_i.v0 && wptr_q == QPTR_W'(i)) begin
        mem_q[i] <= push_i.f0;
      end else if (push_i.v1 && wptr_p1 == QPTR_W'(i)) begin
        mem_q[i] <= push_i.f1;
      end
    end
  end

endmodule

/* design/primitive_face_assembly.sv */
// Primitive face assembler: vertex index beats in, face beats out.
// A face is written to the face queue as its completing vertex beat is accepted; m_axis shows the queue head.
// Throughput: one vertex beat per cycle; a closing line-loop edge adds one
// output beat, absorbed by the four-entry face queue (input held while < 2 free).
// Reset (rst_ni low, async): mode triangles, auto index off, state and queue empty.
// Depends on pfa_pkg, pfa_core and pfa_face_fifo.
module primitive_face_assembly
  import pfa_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [2:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [31:0] vertex_index
  input  logic         s_axis_tlast,   // end_of_primitive
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // corner_a, corner_b, corner_c, corner_count, zero pad
  output logic         m_axis_tlast    // final_of_item
);

  face_pair_t faces;
  face_t      head;
  logic       room2;
  logic       accept;

  assign s_axis_tready = room2;
  assign accept        = s_axis_tvalid & room2;

  pfa_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .vertex_index_i (s_axis_tdata),
    .last_i         (s_axis_tlast),
    .faces_o        (faces)
  );

  pfa_face_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (faces),
    .room2_o (room2),
    .valid_o (m_axis_tvalid),
    .pop_i   (m_axis_tready),
    .face_o  (head)
  );

  assign m_axis_tdata = {6'd0, head.corner_count, head.corner_c, head.corner_b,
                         head.corner_a};
  assign m_axis_tlast = head.final_of_item;

endmodule

/* dv/testbench.sv */
// Self-checking bench for primitive_face_assembly: vertex beats in, face beats out.
// A scoreboard class predicts the faces and checks them in order, beside driver tasks.
// Depends on pfa_pkg and the primitive_face_assembly RTL.
module testbench;
  import pfa_pkg::*;

  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 115;

  class face_scoreboard;
    face_t       expected_faces[$];
    logic [2:0]  mode;
    logic        auto_on;
    logic [31:0] first_v, prev_v, older_v, position;
    logic [1:0]  fill;
    int          mismatches, vertices_seen, faces_checked, loop_closures, swapped_faces;

    function new();
      mode = PRIM_MODE_RESET;
      auto_on = 1'b0;
      clear_state();
      mismatches = 0;
      vertices_seen = 0;
      faces_checked = 0;
      loop_closures = 0;
      swapped_faces = 0;
    endfunction

    function void clear_state();
      first_v = '0;
      prev_v = '0;
      older_v = '0;
      position = '0;
      fill = '0;
    endfunction

    function void write_reg(logic idx, logic [2:0] val);
      if (idx == REG_PRIM_MODE) mode = val;
      else auto_on = val[0];
    endfunction

    function void add_face(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [1:0] cnt);
      face_t f;
      f.corner_a = a;
      f.corner_b = b;
      f.corner_c = c;
      f.corner_count = cnt;
      f.final_of_item = 1'b0;
      expected_faces.insert(expected_faces.size(), f);
    endfunction

    function void note_vertex(logic [31:0] in_idx, logic last);
      logic [31:0] idx;
      logic [1:0]  sat;
      int          held;
      idx = (auto_on ? position : in_idx) & IDX_MASK;
      sat = (fill >= 2'd2) ? 2'd2 : fill + 2'd1;
      held = expected_faces.size();
      vertices_seen++;
      case (mode)
        MODE_POINTS: add_face(idx, '0, '0, CNT_POINT);
        MODE_LINES: begin
          if (fill == 2'd0) begin
            fill = 2'd1;
          end else begin
            add_face(prev_v, idx, '0, CNT_LINE);
            fill = 2'd0;
          end
        end
        MODE_TRIANGLES: begin
          if (fill >= 2'd2) begin
            add_face(older_v, prev_v, idx, CNT_TRI);
            fill = 2'd0;
          end else begin
            fill = fill + 2'd1;
          end
        end
        MODE_LINE_STRIP: begin
          if (fill >= 2'd1) add_face(prev_v, idx, '0, CNT_LINE);
          fill = sat;
        end
        MODE_LINE_LOOP: begin
          if (fill == 2'd0) first_v = idx;
          else add_face(prev_v, idx, '0, CNT_LINE);
          if (last && fill >= 2'd1) begin
            add_face(idx, first_v, '0, CNT_LINE);
            loop_closures++;
          end
          fill = sat;
        end
        MODE_TRI_STRIP: begin
          if (fill >= 2'd2) begin
            if (position[0]) begin
              add_face(prev_v, older_v, idx, CNT_TRI);
              swapped_faces++;
            end else begin
              add_face(older_v, prev_v, idx, CNT_TRI);
            end
          end
          fill = sat;
        end
        MODE_TRI_FAN: begin
          if (fill == 2'd0) first_v = idx;
          if (fill >= 2'd2) add_face(first_v, prev_v, idx, CNT_TRI);
          fill = sat;
        end
        default: ;
      endcase
      older_v = prev_v;
      prev_v = idx;
      position = position + 32'd1;
      if (expected_faces.size() > held)
        expected_faces[expected_faces.size() - 1].final_of_item = 1'b1;
      if (last) clear_state();
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("face mismatch on %s: expected %h, got %h", field, want, got);
    endfunction

    function void check_face(logic [103:0] data, logic fin);
      face_t got, want;
      got.corner_a = data[31:0];
      got.corner_b = data[63:32];
      got.corner_c = data[95:64];
      got.corner_count = data[97:96];
      got.final_of_item = fin;
      faces_checked++;
      if (expected_faces.size() == 0) begin
        report("unexpected face, corner_a", '0, got.corner_a);
      end else begin
        want = expected_faces.pop_front();
        if (got.corner_a !== want.corner_a) report("corner_a", want.corner_a, got.corner_a);
        if (got.corner_b !== want.corner_b) report("corner_b", want.corner_b, got.corner_b);
        if (got.corner_c !== want.corner_c) report("corner_c", want.corner_c, got.corner_c);
        if (got.corner_count !== want.corner_count)
          report("corner_count", 32'(want.corner_count), 32'(got.corner_count));
        if (got.final_of_item !== want.final_of_item)
          report("final_of_item", 32'(want.final_of_item), 32'(got.final_of_item));
      end
    endfunction
  endclass

  typedef struct packed {
    logic [2:0] mode;
    logic       auto_on;
  } setting_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic         cfg_idx_i = 1'b0;
  logic [2:0]   cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tlast;

  face_scoreboard sb;
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int settings_run = 0;

  primitive_face_assembly DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (!rst_ni) begin
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 8);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_vertex(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_face(m_axis_tdata, m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no beat accepted for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_vertex(logic [31:0] idx, logic last);
    while (!calm && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= idx;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // wait on the clock first so the last accepted beat is already in the scoreboard
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_faces.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [2:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [31:0] pick_index();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  // mostly whole primitives; some noise with random end flags; may stop mid-primitive
  task automatic run_phase(int items, bit mid_drain);
    int sent, len;
    bit drained;
    sent = 0;
    drained = 1'b0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) send_vertex(pick_index(), 1'($urandom_range(1)));
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) send_vertex(pick_index(), i == len - 1);
      end
      sent += len;
      if (mid_drain && !drained && sent >= items / 2) begin
        drained = 1'b1;
        settle();
      end
    end
    if ($urandom_range(2) == 0) begin
      len = $urandom_range(1, 2);
      for (int i = 0; i < len; i++) send_vertex(pick_index(), 1'b0);
    end
    settle();
  endtask

  initial begin
    setting_t plan[$];
    setting_t s;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: triangles, trailing partial group dropped
    send_vertex(32'hFFFF_FFFF, 1'b0);
    send_vertex(32'h0000_0000, 1'b0);
    send_vertex(32'hAAAA_AAAA, 1'b0);
    send_vertex(32'h5555_5555, 1'b0);
    send_vertex(32'h1234_5678, 1'b1);
    // two vertices into a triangle, then finish as lines
    send_vertex(32'd1, 1'b0);
    send_vertex(32'd2, 1'b0);
    settle();
    write_reg(REG_PRIM_MODE, MODE_LINES);
    send_vertex(32'd3, 1'b1);
    settle();
    write_reg(REG_PRIM_MODE, MODE_LINE_LOOP);
    send_vertex(32'd9, 1'b1);
    send_vertex(32'd10, 1'b0);
    send_vertex(32'd11, 1'b0);
    send_vertex(32'd12, 1'b1);
    settle();
    write_reg(REG_PRIM_MODE, MODE_TRI_STRIP);
    for (int i = 0; i < 5; i++) send_vertex(32'(20 + i), i == 4);
    settle();
    write_reg(REG_PRIM_MODE, MODE_TRI_FAN);
    send_vertex(32'd30, 1'b0);
    send_vertex(32'd31, 1'b1);
    for (int i = 0; i < 4; i++) send_vertex(32'(40 + i), i == 3);
    settle();
    write_reg(REG_PRIM_MODE, MODE_UNUSED);
    send_vertex(32'd50, 1'b0);
    send_vertex(32'd51, 1'b1);
    settle();
    write_reg(REG_PRIM_MODE, MODE_POINTS);
    write_reg(REG_AUTO_INDEX, 3'd1);
    send_vertex(32'hDEAD_BEEF, 1'b0);
    send_vertex(32'hFFFF_FFFF, 1'b0);
    send_vertex(32'd0, 1'b1);
    settle();

    for (int m = 0; m < 7; m++) begin
      for (int a = 0; a < 2; a++) begin
        s.mode = 3'(m);
        s.auto_on = 1'(a);
        plan.insert(plan.size(), s);
      end
    end
    s.mode = MODE_UNUSED;
    s.auto_on = 1'b0;
    plan.insert(plan.size(), s);
    plan.shuffle();

    foreach (plan[p]) begin
      write_reg(REG_PRIM_MODE, plan[p].mode);
      write_reg(REG_AUTO_INDEX, {2'b00, plan[p].auto_on});
      settings_run++;
      calm = (p == 2);
      if (p == 5) hold_request = 1'b1;
      run_phase(PHASE_ITEMS, p == 9);
    end
    calm = 1'b0;

    settle();
    repeat (10) @(posedge clk_i);
    $display("%0d vertex beats over %0d random settings plus directed cases; %0d face beats",
             sb.vertices_seen, settings_run, sb.faces_checked);
    $display("checked, incl. %0d loop closing edges and %0d swapped strip faces",
             sb.loop_closures, sb.swapped_faces);
    if (sb.mismatches == 0 && sb.expected_faces.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d faces missing", sb.mismatches, sb.expected_faces.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
